FILE: src/assert_macros.svh
// Assertion macros shared by the rate limiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/pslr_pkg.sv
// Types and constants shared by the per-source rate limiter.
package pslr_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 128;
  localparam int unsigned ADDR_W            = 64;
  localparam int unsigned TIME_W            = 64;
  localparam int unsigned THR_W             = 32;
  localparam int unsigned SLOT_W            = 7;

  localparam logic [THR_W-1:0]  THR_RESET   = 32'd500000000;
  localparam logic [ADDR_W-1:0] V4_LOOPBACK = 64'h0000_0000_7F00_0001;
  localparam logic [ADDR_W-1:0] V6_LOOP_LO  = 64'h0000_0000_0000_0001;

  // One packet arrival
  typedef struct packed {
    logic              is_ipv6;
    logic [ADDR_W-1:0] source_addr_hi;
    logic [ADDR_W-1:0] source_addr_lo;
    logic [TIME_W-1:0] arrival_time_ns;
  } in_item_t;

  // One lookup result
  typedef struct packed {
    logic              limited;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
  } out_item_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [TIME_W-1:0] then_time;
  } tok_t;

endpackage

FILE: src/pslr_cell.sv
// One table cell: holds a source entry and passes the search token on.
module pslr_cell #(
  parameter int unsigned IdxW    = 7,
  parameter int unsigned CntW    = 8,
  parameter int unsigned CellIdx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pslr_pkg::in_item_t  query_i,
  input  logic                q_loop_i,
  input  logic [CntW-1:0]     fill_i,
  input  logic                ins_en_i,
  input  logic [IdxW-1:0]     ins_idx_i,
  input  pslr_pkg::tok_t      tok_i,
  input  logic [IdxW-1:0]     slot_i,
  output pslr_pkg::tok_t      tok_o,
  output logic [IdxW-1:0]     slot_o
);
  import pslr_pkg::*;

  // stored entry
  logic              fam_q;
  logic              loop_q;
  logic [ADDR_W-1:0] hi_q;
  logic [ADDR_W-1:0] lo_q;
  logic [TIME_W-1:0] time_q;

  tok_t              tok_q, tok_d;
  logic [IdxW-1:0]   slot_q, slot_d;

  logic filled;
  logic match;
  logic take;
  logic wr;

  // match against the broadcast query; only filled slots take part
  assign filled = fill_i > CntW'(CellIdx);
  assign match  = filled && (fam_q == query_i.is_ipv6) &&
                  (((hi_q == query_i.source_addr_hi) && (lo_q == query_i.source_addr_lo)) ||
                   loop_q || q_loop_i);
  assign take   = tok_i.valid && !tok_i.hit && match;
  assign wr     = take || (ins_en_i && (ins_idx_i == IdxW'(CellIdx)));

  // entry update: on first match or on insert
  always_ff @(posedge clk_i) begin
    if (wr) begin
      fam_q  <= query_i.is_ipv6;
      loop_q <= q_loop_i;
      hi_q   <= query_i.source_addr_hi;
      lo_q   <= query_i.source_addr_lo;
      time_q <= query_i.arrival_time_ns;
    end
  end

  // token forwarding, first match claims it
  always_comb begin
    tok_d  = tok_i;
    slot_d = slot_i;
    if (take) begin
      tok_d.hit       = 1'b1;
      tok_d.then_time = time_q;
      slot_d          = IdxW'(CellIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      slot_q <= '0;
    end else begin
      tok_q  <= tok_d;
      slot_q <= slot_d;
    end
  end

  assign tok_o  = tok_q;
  assign slot_o = slot_q;

endmodule

FILE: src/per_source_rate_limiter.sv
// Per-source rate limiter: top level with control and the chain of table cells.
//
// Each accepted packet is looked up in a table of TableEntries recent sources held in
// a chain of cells. A search token enters the first cell in the cycle after the
// transfer and moves one cell per cycle; the first filled cell whose entry matches
// claims it and rewrites itself with the new address and time. A miss is inserted
// after the token leaves the last cell. The result is presented after the token walk
// through the chain, the exit capture, the time gap and the output register. The block
// takes one item at a time, so the next item is accepted only once the result has
// been loaded into the output register; a new item is accepted while a finished
// result waits at the output. The table needs no clearing pass after reset.
`include "assert_macros.svh"

module per_source_rate_limiter #(
  parameter int unsigned TableEntries = pslr_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  pslr_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output pslr_pkg::out_item_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic [pslr_pkg::THR_W-1:0] cfg_wdata_i
);
  import pslr_pkg::*;

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_GAP,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic              start_q;
  in_item_t          q_q;
  logic              qloop_q;
  logic [THR_W-1:0]  thr_q;
  logic [CntW-1:0]   fill_q;
  logic [IdxW-1:0]   old_q;
  logic              hit_q;
  logic              ev_q;
  logic [IdxW-1:0]   slot_q;
  logic [TIME_W-1:0] then_q;
  logic [TIME_W-1:0] gap_q;
  logic              out_valid_q;
  out_item_t         out_q;

  in_item_t          norm;
  logic              norm_loop;
  logic              full;
  logic              ins_en;
  logic [IdxW-1:0]   ins_idx;
  tok_t              exit_tok;

  tok_t              tok_w  [TableEntries+1];
  logic [IdxW-1:0]   slot_w [TableEntries+1];

  // IPv4 keeps only the low 32 address bits
  always_comb begin
    norm = in_data_i;
    if (!in_data_i.is_ipv6) begin
      norm.source_addr_hi = '0;
      norm.source_addr_lo = {32'b0, in_data_i.source_addr_lo[31:0]};
    end
    norm_loop = norm.is_ipv6 ? ((norm.source_addr_hi == '0) &&
                                (norm.source_addr_lo == V6_LOOP_LO))
                             : (norm.source_addr_lo == V4_LOOPBACK);
  end

  // chain of cells
  assign tok_w[0]  = '{valid: start_q, hit: 1'b0, then_time: '0};
  assign slot_w[0] = '0;

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    pslr_cell #(
      .IdxW    (IdxW),
      .CntW    (CntW),
      .CellIdx (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .query_i   (q_q),
      .q_loop_i  (qloop_q),
      .fill_i    (fill_q),
      .ins_en_i  (ins_en),
      .ins_idx_i (ins_idx),
      .tok_i     (tok_w[g]),
      .slot_i    (slot_w[g]),
      .tok_o     (tok_w[g+1]),
      .slot_o    (slot_w[g+1])
    );
  end

  assign exit_tok = tok_w[TableEntries];

  // insert on a miss: free slot while filling, else the oldest
  assign full    = fill_q == CntW'(TableEntries);
  assign ins_en  = (state_q == ST_RUN) && exit_tok.valid && !exit_tok.hit;
  assign ins_idx = full ? old_q : fill_q[IdxW-1:0];

  // control, table bookkeeping and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      q_q         <= '0;
      qloop_q     <= 1'b0;
      thr_q       <= THR_RESET;
      fill_q      <= '0;
      old_q       <= '0;
      hit_q       <= 1'b0;
      ev_q        <= 1'b0;
      slot_q      <= '0;
      then_q      <= '0;
      gap_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      start_q <= 1'b0;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      // result taken and no new one loaded this cycle
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            q_q     <= norm;
            qloop_q <= norm_loop;
            start_q <= 1'b1;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (exit_tok.valid) begin
            hit_q  <= exit_tok.hit;
            then_q <= exit_tok.then_time;
            slot_q <= exit_tok.hit ? slot_w[TableEntries] : ins_idx;
            ev_q   <= !exit_tok.hit && full;
            if (!exit_tok.hit) begin
              if (full) begin
                old_q <= (old_q == IdxW'(TableEntries - 1)) ? '0 : old_q + IdxW'(1);
              end else begin
                fill_q <= fill_q + CntW'(1);
              end
            end
            state_q <= ST_GAP;
          end
        end
        ST_GAP: begin
          // absolute time gap
          gap_q   <= (q_q.arrival_time_ns >= then_q) ? (q_q.arrival_time_ns - then_q)
                                                     : (then_q - q_q.arrival_time_ns);
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_q       <= '{limited: hit_q && (gap_q <= TIME_W'(thr_q)),
                             found:   hit_q,
                             slot:    SLOT_W'(slot_q),
                             evicted: ev_q};
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= CntW'(TableEntries))
  `ASSERT_IMP(a_old_zero_filling, !full, old_q == '0)
  `ASSERT_IMP(a_idle_chain_empty, state_q == ST_IDLE, !exit_tok.valid)
  `ASSERT_NXT(a_insert_grows, ins_en && !full, fill_q == $past(fill_q) + CntW'(1))

endmodule
